@@ hdl/c3f_pkg.sv @@
package c3f_pkg;

	// default geometry limits and channel count
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_CHANNELS   = 3;

	// fixed field widths
	localparam int PX_W      = 8;
	localparam int CH_MAX    = 3;
	localparam int PIX_W     = CH_MAX * PX_W;
	localparam int CF_W      = 8;
	localparam int PROD_W    = PX_W + CF_W + 1;
	localparam int RSUM_W    = PROD_W + 2;
	localparam int SUM_W     = RSUM_W + 2;
	localparam int FRAC_BITS = 4;
	localparam int IMG_W_W   = 12;
	localparam int IMG_H_W   = 13;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_MID = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_BOT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd4;

	// reset contents
	localparam int RST_IMG_WIDTH  = 640;
	localparam int RST_IMG_HEIGHT = 480;

	localparam logic [PX_W-1:0] PX_MAX = 8'd255;

	// one pixel, channel 0 in the low byte
	typedef logic [PIX_W-1:0] pix_t;

	// one kernel row, left coefficient in the low byte
	typedef logic [2:0][CF_W-1:0] krow_t;

	// 3x3 window of pixels, [row][column], column 0 the oldest
	typedef logic [2:0][2:0][PIX_W-1:0] win_t;

	// one channel of the window and the kernel, as seen by a lane
	typedef logic [2:0][2:0][PX_W-1:0] lane_px_t;
	typedef logic [2:0][2:0][CF_W-1:0] lane_cf_t;

endpackage

@@ hdl/c3f_linebuf.sv @@
module c3f_linebuf import c3f_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  pix_t                         pix,
	input  logic                         sh_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] sh_addr,
	output win_t                         win
);

	pix_t mem_upper [MAX_WIDTH];
	pix_t mem_lower [MAX_WIDTH];

	pix_t up_s1;
	pix_t lo_s1;
	pix_t pix_s1;
	win_t win_q;

	// lower store: new pixel in, previous line out (read-first)
	always_ff @(posedge clk) begin
		if (rd_en) begin
			lo_s1              <= mem_lower[rd_addr];
			mem_lower[rd_addr] <= pix;
			pix_s1             <= pix;
		end
	end

	// upper store: read on transfer, gets the lower line one stage later
	always_ff @(posedge clk) begin
		if (rd_en) begin
			up_s1 <= mem_upper[rd_addr];
		end
		if (sh_en) begin
			mem_upper[sh_addr] <= lo_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (sh_en) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= up_s1;
			win_q[1][2] <= lo_s1;
			win_q[2][2] <= pix_s1;
		end
	end

	assign win = win_q;

endmodule

@@ hdl/c3f_lane.sv @@
module c3f_lane import c3f_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  lane_px_t        px,
	input  lane_cf_t        cf,
	output logic [PX_W-1:0] res
);

	logic signed [PROD_W-1:0] prod_s3 [3][3];
	logic signed [RSUM_W-1:0] rsum_s4 [3];
	logic [PX_W-1:0]          res_s5;

	logic signed [SUM_W-1:0]       sum;
	logic [SUM_W-FRAC_BITS-1:0]    shifted;

	// nine products, unsigned sample times signed coefficient
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s3[r][k] <= PROD_W'($signed({1'b0, px[r][k]}) * $signed(cf[r][k]));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				rsum_s4[r] <= RSUM_W'(prod_s3[r][0]) + RSUM_W'(prod_s3[r][1])
					+ RSUM_W'(prod_s3[r][2]);
			end
		end
	end

	// total, floor at zero, drop fraction, saturate at full scale
	always_comb begin
		sum     = SUM_W'(rsum_s4[0]) + SUM_W'(rsum_s4[1]) + SUM_W'(rsum_s4[2]);
		shifted = sum[SUM_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum[SUM_W-1]) begin
				res_s5 <= '0;
			end else if (|shifted[SUM_W-FRAC_BITS-1:PX_W]) begin
				res_s5 <= PX_MAX;
			end else begin
				res_s5 <= shifted[PX_W-1:0];
			end
		end
	end

	assign res = res_s5;

endmodule

@@ hdl/conv3x3_clamped_filter.sv @@
// 3x3 convolution filter over a raster pixel stream, three 8-bit channels
// input channel: in_valid / in_stall carry one pixel per transfer, in raster
//   order from the top left corner of the frame
// output channel: out_valid / out_stall carry one filtered pixel per transfer
//   with its column and row; only interior pixels are produced, so a frame of
//   w x h pixels yields (w-2) x (h-2) results
// config channel: cfg_valid / cfg_ready (always ready), cfg_index picks the
//   register: kernel rows top, mid, bottom, then image width and height
// throughput: one pixel per cycle while in_stall is low, set by the single write
//   port of each line store and the fully pipelined lanes
// path: after the transfer of the pixel that completes its window, a result passes
//   the line store read, window, multiply, row sum, clamp and output registers
// reset: identity kernel, 640 x 480 frame, position counters at the top left;
//   line stores hold no defined data until a line has passed
// receiver stall: the output register holds its result; the pipeline keeps
//   taking pixels until a finished result sits behind the output register,
//   then in_stall rises and everything freezes until out_stall drops
module conv3x3_clamped_filter import c3f_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int CHANNELS   = DEF_CHANNELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [PX_W-1:0]               pixel_ch0,
	input  logic [PX_W-1:0]               pixel_ch1,
	input  logic [PX_W-1:0]               pixel_ch2,
	// filtered output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [PX_W-1:0]               out_ch0,
	output logic [PX_W-1:0]               out_ch1,
	output logic [PX_W-1:0]               out_ch2,
	output logic [$clog2(MAX_WIDTH)-1:0]  out_col,
	output logic [$clog2(MAX_HEIGHT)-1:0] out_row,
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int LANES = (CHANNELS > CH_MAX) ? CH_MAX : CHANNELS;

	// saturation of the geometry registers to the supported range
	localparam int WCMP_W = (IMG_W_W > $clog2(MAX_WIDTH + 1)) ? IMG_W_W : $clog2(MAX_WIDTH + 1);
	localparam int HCMP_W = (IMG_H_W > $clog2(MAX_HEIGHT + 1)) ? IMG_H_W : $clog2(MAX_HEIGHT + 1);
	localparam logic [WCMP_W-1:0] W_MIN = WCMP_W'(3);
	localparam logic [WCMP_W-1:0] W_MAX = WCMP_W'(MAX_WIDTH);
	localparam logic [HCMP_W-1:0] H_MIN = HCMP_W'(3);
	localparam logic [HCMP_W-1:0] H_MAX = HCMP_W'(MAX_HEIGHT);
	localparam int W_RST = (RST_IMG_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMG_WIDTH;
	localparam int H_RST = (RST_IMG_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMG_HEIGHT;
	localparam logic [COL_W-1:0] WLAST_RST = COL_W'(W_RST - 1);
	localparam logic [ROW_W-1:0] HLAST_RST = ROW_W'(H_RST - 1);
	localparam krow_t KMID_RST = krow_t'(24'h001000);

	// configuration state: kernel rows and last column / row of the frame
	krow_t            coef_top_q;
	krow_t            coef_mid_q;
	krow_t            coef_bot_q;
	logic [COL_W-1:0] wlast_q;
	logic [ROW_W-1:0] hlast_q;

	logic              cfg_we;
	logic [WCMP_W-1:0] w_raw;
	logic [WCMP_W-1:0] w_sat;
	logic [HCMP_W-1:0] h_raw;
	logic [HCMP_W-1:0] h_sat;

	// position of the next incoming pixel
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// pipeline control
	logic             adv;
	logic             in_acc;
	pix_t             pix_in;
	logic             vld_s1;
	logic             prd_s1;
	logic             prd_s2;
	logic             prd_s3;
	logic             prd_s4;
	logic             prd_s5;
	logic [COL_W-1:0] col_s1, col_s2, col_s3, col_s4, col_s5;
	logic [ROW_W-1:0] row_s1, row_s2, row_s3, row_s4, row_s5;

	win_t             win;
	lane_cf_t         kern;
	logic [CH_MAX-1:0][PX_W-1:0] lane_res;

	// output register
	logic                  out_valid_q;
	logic [PX_W-1:0]       out_ch0_q, out_ch1_q, out_ch2_q;
	logic [COL_W-1:0]      out_col_q;
	logic [ROW_W-1:0]      out_row_q;

	//--------------------------------------------------------------------
	// configuration registers
	//--------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	always_comb begin
		w_raw = WCMP_W'(cfg_data[IMG_W_W-1:0]);
		h_raw = HCMP_W'(cfg_data[IMG_H_W-1:0]);
		if (w_raw < W_MIN) begin
			w_sat = W_MIN;
		end else if (w_raw > W_MAX) begin
			w_sat = W_MAX;
		end else begin
			w_sat = w_raw;
		end
		if (h_raw < H_MIN) begin
			h_sat = H_MIN;
		end else if (h_raw > H_MAX) begin
			h_sat = H_MAX;
		end else begin
			h_sat = h_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q <= '0;
			coef_mid_q <= KMID_RST;
			coef_bot_q <= '0;
			wlast_q    <= WLAST_RST;
			hlast_q    <= HLAST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEFF_TOP:  coef_top_q <= krow_t'(cfg_data);
				REG_COEFF_MID:  coef_mid_q <= krow_t'(cfg_data);
				REG_COEFF_BOT:  coef_bot_q <= krow_t'(cfg_data);
				REG_IMG_WIDTH:  wlast_q    <= COL_W'(w_sat - 1'b1);
				REG_IMG_HEIGHT: hlast_q    <= ROW_W'(h_sat - 1'b1);
				default: begin
				end
			endcase
		end
	end

	//--------------------------------------------------------------------
	// flow control: freeze only when a finished result waits behind a
	// stalled output register
	//--------------------------------------------------------------------
	assign adv      = !(prd_s5 && out_valid_q && out_stall);
	assign in_stall = !adv;
	assign in_acc   = in_valid && adv;

	// channels beyond the configured count are carried as zero
	always_comb begin
		pix_in = '0;
		pix_in[PX_W-1:0] = pixel_ch0;
		if (LANES > 1) begin
			pix_in[2*PX_W-1:PX_W] = pixel_ch1;
		end
		if (LANES > 2) begin
			pix_in[3*PX_W-1:2*PX_W] = pixel_ch2;
		end
	end

	//--------------------------------------------------------------------
	// raster position; a count past a shrunken limit wraps at its next step
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_q >= wlast_q) begin
				col_q <= '0;
				row_q <= (row_q >= hlast_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	//--------------------------------------------------------------------
	// valid and position pipeline alongside the data path
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			prd_s2 <= 1'b0;
			prd_s3 <= 1'b0;
			prd_s4 <= 1'b0;
			prd_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			prd_s2 <= vld_s1 && prd_s1;
			prd_s3 <= prd_s2;
			prd_s4 <= prd_s3;
			prd_s5 <= prd_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// window complete once two lines and two columns have passed
			prd_s1 <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			col_s1 <= col_q;
			row_s1 <= row_q;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			col_s3 <= col_s2;
			row_s3 <= row_s2;
			col_s4 <= col_s3;
			row_s4 <= row_s3;
			col_s5 <= col_s4;
			row_s5 <= row_s4;
		end
	end

	//--------------------------------------------------------------------
	// line stores and window
	//--------------------------------------------------------------------
	c3f_linebuf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.pix     (pix_in),
		.sh_en   (adv && vld_s1),
		.sh_addr (col_s1),
		.win     (win)
	);

	//--------------------------------------------------------------------
	// one lane per channel, all sharing the kernel
	//--------------------------------------------------------------------
	assign kern[0] = coef_top_q;
	assign kern[1] = coef_mid_q;
	assign kern[2] = coef_bot_q;

	for (genvar c = 0; c < CH_MAX; c++) begin : g_lane
		if (c < LANES) begin : g_on
			lane_px_t px;

			always_comb begin
				for (int r = 0; r < 3; r++) begin
					for (int k = 0; k < 3; k++) begin
						px[r][k] = win[r][k][c*PX_W +: PX_W];
					end
				end
			end

			c3f_lane u_lane (
				.clk (clk),
				.en  (adv),
				.px  (px),
				.cf  (kern),
				.res (lane_res[c])
			);
		end else begin : g_off
			assign lane_res[c] = '0;
		end
	end

	//--------------------------------------------------------------------
	// merge: lane results and window centre position into the output register
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && prd_s5) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && prd_s5) begin
			out_ch0_q <= lane_res[0];
			out_ch1_q <= lane_res[1];
			out_ch2_q <= lane_res[2];
			out_col_q <= col_s5 - 1'b1;
			out_row_q <= row_s5 - 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_ch0   = out_ch0_q;
	assign out_ch1   = out_ch1_q;
	assign out_ch2   = out_ch2_q;
	assign out_col   = out_col_q;
	assign out_row   = out_row_q;

`ifndef SYNTHESIS
	// input held back only behind a finished result at a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && prd_s5))
		else $error("input stalled without a blocked result");

	// every result is an interior pixel
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_col != '0 && out_row != '0))
		else $error("border pixel produced");

	// a new result only comes out of the last lane stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(prd_s5))
		else $error("result without a finished lane stage");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import c3f_pkg::*;

	// position field widths of a filtered pixel, as the block sizes them
	localparam int COL_W = $clog2(DEF_MAX_WIDTH);
	localparam int ROW_W = $clog2(DEF_MAX_HEIGHT);

	// smallest frame side the block accepts; smaller settings saturate to it
	localparam int unsigned MIN_DIM = 3;

	// kernel rows used by the directed frames
	localparam krow_t KROW_IDENTITY = 24'h001000;	// centre tap of 16/16
	localparam krow_t KROW_ALL_POS  = 24'h7F7F7F;	// every tap +127/16
	localparam krow_t KROW_ALL_NEG  = 24'h808080;	// every tap -128/16

	// register indexes the block ignores
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	// kernel row registers, top row at index 0
	localparam logic [2:0][CFG_IDX_W-1:0] KROW_REGS =
		{REG_COEFF_BOT, REG_COEFF_MID, REG_COEFF_TOP};

	localparam int RAND_PIXELS  = 750;
	localparam int SETTLE_CYCLES = 16;	// margin for the pipeline to empty
	localparam int CYCLE_LIMIT  = 3_000_000;

	// one filtered pixel: channels packed like pix_t, then its position
	typedef struct packed {
		logic [2:0][PX_W-1:0] chan;
		logic [COL_W-1:0]     col;
		logic [ROW_W-1:0]     row;
	} fpix_t;

	typedef enum {DIR_CFG, DIR_PIX} dir_kind_e;

	// one line of the directed stimulus table
	typedef struct {
		dir_kind_e            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		pix_t                 pix;
		bit                   typed;	// want holds a hand-written expectation
		fpix_t                want;
	} dir_row_t;

	// receiver behavior, a mode picked at random when the current one runs out
	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_e;

	logic clk;
	logic arst_n = 1'b0;

	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [PX_W-1:0]   pixel_ch0 = '0;
	logic [PX_W-1:0]   pixel_ch1 = '0;
	logic [PX_W-1:0]   pixel_ch2 = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [PX_W-1:0]   out_ch0;
	logic [PX_W-1:0]   out_ch1;
	logic [PX_W-1:0]   out_ch2;
	logic [COL_W-1:0]  out_col;
	logic [ROW_W-1:0]  out_row;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	conv3x3_clamped_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_ch0 (pixel_ch0),
		.pixel_ch1 (pixel_ch1),
		.pixel_ch2 (pixel_ch2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_ch0   (out_ch0),
		.out_ch1   (out_ch1),
		.out_ch2   (out_ch2),
		.out_col   (out_col),
		.out_row   (out_row),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// filter model: own copy of the line stores, window, counters and regs
	// ------------------------------------------------------------------
	pix_t                 line_up [DEF_MAX_WIDTH];	// two lines back
	pix_t                 line_lo [DEF_MAX_WIDTH];	// one line back
	pix_t                 nbhd [3][3];	// [row][col], col 0 the oldest
	krow_t                kern [3];
	logic [IMG_W_W-1:0]   width_reg;
	logic [IMG_H_W-1:0]   height_reg;
	int unsigned          col_pos;	// position of the next pixel in
	int unsigned          row_pos;

	// filtered pixels not yet seen on the output, oldest first
	fpix_t due_pixels[$];

	int          fail_count  = 0;
	int unsigned pixels_sent = 0;
	int unsigned burst_left  = 10;
	int unsigned cycle_count = 0;

	function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// push one pixel through the model; returns 1 when it completes a window
	function automatic bit filter_pixel(input pix_t p, output fpix_t r);
		int unsigned w, h, cur_col, cur_row;
		pix_t up, lo;
		int acc, pv, cv, ch, ry, kx;
		bit fired;
		w = clip(width_reg, MIN_DIM, DEF_MAX_WIDTH);
		h = clip(height_reg, MIN_DIM, DEF_MAX_HEIGHT);
		cur_col = col_pos;
		cur_row = row_pos;

		// line stores move down one line at this column
		up = line_up[cur_col];
		lo = line_lo[cur_col];
		line_up[cur_col] = lo;
		line_lo[cur_col] = p;

		for (ry = 0; ry < 3; ry++) begin
			nbhd[ry][0] = nbhd[ry][1];
			nbhd[ry][1] = nbhd[ry][2];
		end
		nbhd[0][2] = up;
		nbhd[1][2] = lo;
		nbhd[2][2] = p;

		fired = (cur_row >= 2) && (cur_col >= 2);
		r = '0;
		if (fired) begin
			for (ch = 0; ch < 3; ch++) begin
				acc = 0;
				for (ry = 0; ry < 3; ry++)
					for (kx = 0; kx < 3; kx++) begin
						pv = nbhd[ry][kx][PX_W*ch +: PX_W];
						cv = $signed(kern[ry][kx]);
						acc += pv * cv;
					end
				// floor at zero, drop the 1/16 fraction, saturate
				if (acc < 0)
					acc = 0;
				acc = acc >>> FRAC_BITS;
				if (acc > PX_MAX)
					acc = PX_MAX;
				r.chan[ch] = acc[PX_W-1:0];
			end
			r.col = COL_W'(cur_col - 1);
			r.row = ROW_W'(cur_row - 1);
		end

		// raster advance; a count past a shrunk limit wraps here
		if (cur_col + 1 >= w) begin
			col_pos = 0;
			row_pos = (cur_row + 1 >= h) ? 0 : cur_row + 1;
		end else begin
			col_pos = cur_col + 1;
		end
		return fired;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// one pixel transfer; the expectation is the typed one or the model's
	task automatic send_pixel(input pix_t p, input bit typed, input fpix_t want);
		fpix_t got;
		bit fired;
		pixel_ch0 <= p[7:0];
		pixel_ch1 <= p[15:8];
		pixel_ch2 <= p[23:16];
		in_valid  <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		fired = filter_pixel(p, got);
		if (typed)
			due_pixels.push_back(want);
		else if (fired)
			due_pixels.push_back(got);
		pixels_sent++;

		// bursts of random length, with a gap between them
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
			                                         : $urandom_range(1, 12);
		end
	endtask

	// register write; the model takes it at the transfer
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_COEFF_TOP:  kern[0] = data;
			REG_COEFF_MID:  kern[1] = data;
			REG_COEFF_BOT:  kern[2] = data;
			REG_IMG_WIDTH:  width_reg = data[IMG_W_W-1:0];
			REG_IMG_HEIGHT: height_reg = data[IMG_H_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending, wait for every result, then let the pipeline empty
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random channel values, extreme ones now and then
	function automatic pix_t rand_pix();
		pix_t p;
		int i;
		for (i = 0; i < 3; i++)
			case ($urandom_range(0, 7))
				0:       p[PX_W*i +: PX_W] = '0;
				1:       p[PX_W*i +: PX_W] = PX_MAX;
				default: p[PX_W*i +: PX_W] = PX_W'($urandom);
			endcase
		return p;
	endfunction

	// full-range taps saturate nearly always, so most kernels use small taps
	function automatic krow_t pick_krow();
		krow_t k;
		int i;
		bit wide;
		wide = ($urandom_range(0, 3) == 0);
		for (i = 0; i < 3; i++)
			k[i] = wide ? CF_W'($urandom) : CF_W'(int'($urandom_range(0, 16)) - 6);
		return k;
	endfunction

	task automatic load_random_kernel(input bit every_row);
		int j;
		for (j = 0; j < 3; j++)
			if (every_row || $urandom_range(0, 1))
				write_reg(KROW_REGS[j], pick_krow());
	endtask

	// random pixels until the raster counters are back at the top left
	task automatic finish_frame();
		do send_pixel(rand_pix(), 1'b0, '0);
		while (col_pos != 0 || row_pos != 0);
	endtask

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
	                                     input logic [CFG_DATA_W-1:0] data);
		dir_row_t r;
		r.kind  = DIR_CFG;
		r.idx   = idx;
		r.data  = data;
		r.pix   = '0;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic dir_row_t pix_row(input pix_t p, input bit typed, input fpix_t want);
		dir_row_t r;
		r.kind  = DIR_PIX;
		r.idx   = '0;
		r.data  = '0;
		r.pix   = p;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	// a 3x3 frame has one interior pixel, at column 1 row 1
	function automatic fpix_t first_interior(input pix_t v);
		return {v, COL_W'(1), ROW_W'(1)};
	endfunction

	// ------------------------------------------------------------------
	// receiver: stall pattern of its own, independent of the sender
	// ------------------------------------------------------------------
	rx_mode_e    rx_mode   = RX_FREE;
	int unsigned rx_left   = 0;
	int unsigned hold_left = 0;
	bit          hold_on   = 1'b0;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_left = $urandom_range(50, 400);
		end
		rx_left--;
		case (rx_mode)
			RX_FREE:  out_stall <= 1'b0;
			RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				// long stretches of stall and of flow
				if (hold_left == 0) begin
					hold_left = $urandom_range(1, 20);
					hold_on   = !hold_on;
				end
				hold_left--;
				out_stall <= hold_on;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// output checker: every output transfer against the oldest expectation
	// ------------------------------------------------------------------
	fpix_t head_pix;

	task automatic cmp_field(input string name, input logic [11:0] want,
	                         input logic [11:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (due_pixels.size() == 0) begin
				$display("%0t: unexpected output transfer at col %0d row %0d, expected none",
				         $time, out_col, out_row);
				fail_count++;
			end else begin
				head_pix = due_pixels.pop_front();
				cmp_field("out_ch0", head_pix.chan[0], out_ch0);
				cmp_field("out_ch1", head_pix.chan[1], out_ch1);
				cmp_field("out_ch2", head_pix.chan[2], out_ch2);
				cmp_field("out_col", head_pix.col, out_col);
				cmp_field("out_row", head_pix.row, out_row);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	dir_row_t    dir_tab[$];
	pix_t        frame_a [9];
	int unsigned rand_goal, fsz, k, i, b;
	bit          first_phase;

	initial begin
		// model state after reset
		kern[0]    = '0;
		kern[1]    = KROW_IDENTITY;
		kern[2]    = '0;
		width_reg  = RST_IMG_WIDTH;
		height_reg = RST_IMG_HEIGHT;
		col_pos    = 0;
		row_pos    = 0;
		for (i = 0; i < 9; i++)
			nbhd[i / 3][i % 3] = '0;

		// directed table
		// geometry below the minimum, junk above the register width
		dir_tab.push_back(cfg_row(REG_IMG_WIDTH, 24'hABC002));
		dir_tab.push_back(cfg_row(REG_IMG_HEIGHT, 24'h7FE001));
		dir_tab.push_back(cfg_row(REG_SPARE_FIRST, 24'hFFFFFF));
		// reset kernel is the identity, so the one result is the centre pixel
		frame_a = '{24'h000000, 24'hFFFFFF, 24'h0F0F0F, 24'hF0F0F0, 24'hAA00FF,
		            24'h55FF00, 24'h123456, 24'hFEDCBA, 24'h808080};
		for (i = 0; i < 9; i++)
			dir_tab.push_back(pix_row(frame_a[i], i == 8, first_interior(frame_a[4])));
		// largest positive taps on a white frame clamp high
		for (i = 0; i < 3; i++)
			dir_tab.push_back(cfg_row(KROW_REGS[i], KROW_ALL_POS));
		for (i = 0; i < 9; i++)
			dir_tab.push_back(pix_row(24'hFFFFFF, i == 8, first_interior(24'hFFFFFF)));
		// most negative taps give a negative sum that clamps to zero
		for (i = 0; i < 3; i++)
			dir_tab.push_back(cfg_row(KROW_REGS[i], KROW_ALL_NEG));
		for (i = 0; i < 9; i++)
			dir_tab.push_back(pix_row(24'hFFFFFF, i == 8, first_interior(24'h000000)));

		// reset, once
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part; register writes only once the block is idle
		foreach (dir_tab[n]) begin
			if (dir_tab[n].kind == DIR_CFG) begin
				drain();
				write_reg(dir_tab[n].idx, dir_tab[n].data);
			end else begin
				send_pixel(dir_tab[n].pix, dir_tab[n].typed, dir_tab[n].want);
			end
		end

		// random frames of small size, new settings between frames; width only
		// grows at a frame start so no line store entry is read unwritten
		rand_goal   = pixels_sent + RAND_PIXELS;
		first_phase = 1'b1;
		while (pixels_sent < rand_goal) begin
			drain();
			load_random_kernel(first_phase);
			if (first_phase || $urandom_range(0, 1))
				write_reg(REG_IMG_WIDTH, {12'($urandom), ($urandom_range(0, 7) == 0) ?
					IMG_W_W'($urandom_range(21, 64)) : IMG_W_W'($urandom_range(0, 20))});
			if (first_phase || $urandom_range(0, 1))
				write_reg(REG_IMG_HEIGHT,
				          {11'($urandom), IMG_H_W'($urandom_range(0, 9))});
			if ($urandom_range(0, 5) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
				          CFG_DATA_W'($urandom));
			first_phase = 1'b0;

			// now and then change settings in mid-frame: width may only shrink
			if ($urandom_range(0, 2) == 0) begin
				fsz = clip(width_reg, MIN_DIM, DEF_MAX_WIDTH) *
				      clip(height_reg, MIN_DIM, DEF_MAX_HEIGHT);
				k = $urandom_range(1, fsz - 1);
				repeat (k) send_pixel(rand_pix(), 1'b0, '0);
				drain();
				case ($urandom_range(0, 2))
					0: write_reg(REG_IMG_WIDTH, {12'($urandom), IMG_W_W'($urandom_range(0,
						clip(width_reg, MIN_DIM, DEF_MAX_WIDTH)))});
					1: write_reg(REG_IMG_HEIGHT,
					             {11'($urandom), IMG_H_W'($urandom_range(0, 12))});
					default: write_reg(KROW_REGS[$urandom_range(0, 2)], pick_krow());
				endcase
			end
			finish_frame();
		end

		// all-ones settings are masked and saturate to the maximum: a stretch
		// of a widest first line, then a narrow run down a tallest frame; a
		// limit reached early would bring results or move the rows
		for (b = 0; b < 2; b++) begin
			drain();
			load_random_kernel(1'b1);
			write_reg(REG_IMG_WIDTH, (b == 0) ? 24'hFFFFFF
			                                  : {12'($urandom), IMG_W_W'(MIN_DIM)});
			write_reg(REG_IMG_HEIGHT, (b == 0) ? {11'($urandom), IMG_H_W'(MIN_DIM)}
			                                   : 24'hFFFFFF);
			repeat ((b == 0) ? 40 : 60) send_pixel(rand_pix(), 1'b0, '0);
		end

		drain();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ conv3x3_clamped_filter.f @@
hdl/c3f_pkg.sv
hdl/c3f_linebuf.sv
hdl/c3f_lane.sv
hdl/conv3x3_clamped_filter.sv
bench/testbench.sv
